// File: rtl/esud_pkg.sv
`timescale 1ns / 1ps
// Shared types, character codes and decode functions for the escape decoder.
// No dependencies.
package esud_pkg;

    localparam int QueueDepth = 4;
    localparam int QueueAw    = $clog2(QueueDepth);

    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_LX     = 8'h78;
    localparam logic [7:0] CH_LU     = 8'h75;
    localparam logic [7:0] CH_LA     = 8'h61;
    localparam logic [7:0] CH_LB     = 8'h62;
    localparam logic [7:0] CH_LF     = 8'h66;
    localparam logic [7:0] CH_LN     = 8'h6E;
    localparam logic [7:0] CH_LR     = 8'h72;
    localparam logic [7:0] CH_LT     = 8'h74;
    localparam logic [7:0] CH_LV     = 8'h76;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_UA     = 8'h41;
    localparam logic [7:0] CH_UF     = 8'h46;

    typedef enum logic [1:0] {
        PH_TEXT = 2'd0,
        PH_ESC  = 2'd1,
        PH_HEX  = 2'd2
    } phase_t;

    // One request's worth of output: 1 to 3 bytes, or one error result.
    typedef struct packed {
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [1:0] count;
        logic       err;
        logic       eos;
    } job_t;

    typedef struct packed {
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [1:0] count;
    } utf8_t;

    // {valid, value}
    function automatic logic [4:0] hex_digit(input logic [7:0] b);
        logic [7:0] t;
        t = 8'h00;
        hex_digit = 5'd0;
        if (b >= CH_0 && b <= CH_9)
        begin
            t = b - CH_0;
            hex_digit = {1'b1, t[3:0]};
        end
        else if (b >= CH_LA && b <= CH_LF)
        begin
            t = b - CH_LA + 8'd10;
            hex_digit = {1'b1, t[3:0]};
        end
        else if (b >= CH_UA && b <= CH_UF)
        begin
            t = b - CH_UA + 8'd10;
            hex_digit = {1'b1, t[3:0]};
        end
    endfunction

    // {valid, code}
    function automatic logic [8:0] simple_escape(input logic [7:0] b);
        unique case (b)
            CH_BSLASH: simple_escape = {1'b1, 8'h5C};
            CH_SQUOTE: simple_escape = {1'b1, 8'h27};
            CH_DQUOTE: simple_escape = {1'b1, 8'h22};
            CH_LA:     simple_escape = {1'b1, 8'h07};
            CH_LB:     simple_escape = {1'b1, 8'h08};
            CH_LF:     simple_escape = {1'b1, 8'h0C};
            CH_LN:     simple_escape = {1'b1, 8'h0A};
            CH_LR:     simple_escape = {1'b1, 8'h0D};
            CH_LT:     simple_escape = {1'b1, 8'h09};
            CH_LV:     simple_escape = {1'b1, 8'h0B};
            CH_0:      simple_escape = {1'b1, 8'h00};
            default:   simple_escape = {1'b0, 8'h00};
        endcase
    endfunction

    function automatic utf8_t encode_utf8(input logic [15:0] cp);
        utf8_t r;
        r = '0;
        if (cp < 16'h0080)
        begin
            r.b0    = cp[7:0];
            r.count = 2'd1;
        end
        else if (cp < 16'h0800)
        begin
            r.b0    = {3'b110, cp[10:6]};
            r.b1    = {2'b10, cp[5:0]};
            r.count = 2'd2;
        end
        else
        begin
            r.b0    = {4'b1110, cp[15:12]};
            r.b1    = {2'b10, cp[11:6]};
            r.b2    = {2'b10, cp[5:0]};
            r.count = 2'd3;
        end
        return r;
    endfunction

endpackage

// File: rtl/esud_front.sv
`timescale 1ns / 1ps
// Front end: takes input bytes, tracks escape state, builds output jobs.
// Depends on esud_pkg.
module esud_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [7:0]        in_byte,
    input  logic              end_of_string,
    output logic              in_stall,
    input  logic              q_full,
    output logic              push,
    output esud_pkg::job_t    push_job
);

    esud_pkg::phase_t phase_reg, phase_next;
    logic [2:0]       digits_reg, digits_next;
    logic [15:0]      acc_reg, acc_next;
    logic             rejected_reg, rejected_next;

    logic             accept;
    logic             err;
    logic [4:0]       hx;
    logic [8:0]       se;
    logic [15:0]      acc_shift;
    esud_pkg::utf8_t  enc;
    esud_pkg::job_t   job;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;

    always_comb
    begin
        phase_next    = phase_reg;
        digits_next   = digits_reg;
        acc_next      = acc_reg;
        rejected_next = rejected_reg;
        err           = 1'b0;
        job           = '0;
        job.eos       = end_of_string;
        hx            = esud_pkg::hex_digit(in_byte);
        se            = esud_pkg::simple_escape(in_byte);
        acc_shift     = {acc_reg[11:0], hx[3:0]};
        enc           = esud_pkg::encode_utf8(acc_shift);

        if (rejected_reg)
        begin
            if (end_of_string)
            begin
                job.count     = 2'd1;
                job.err       = 1'b1;
                phase_next    = esud_pkg::PH_TEXT;
                digits_next   = 3'd0;
                acc_next      = 16'h0000;
                rejected_next = 1'b0;
            end
        end
        else
        begin
            unique case (phase_reg)
                esud_pkg::PH_ESC:
                begin
                    if (in_byte == esud_pkg::CH_LX || in_byte == esud_pkg::CH_LU)
                    begin
                        digits_next = (in_byte == esud_pkg::CH_LX) ? 3'd2 : 3'd4;
                        acc_next    = 16'h0000;
                        phase_next  = esud_pkg::PH_HEX;
                    end
                    else if (!se[8])
                        err = 1'b1;
                    else
                    begin
                        job.b0     = se[7:0];
                        job.count  = 2'd1;
                        phase_next = esud_pkg::PH_TEXT;
                    end
                end
                esud_pkg::PH_HEX:
                begin
                    if (!hx[4])
                        err = 1'b1;
                    else if (digits_reg <= 3'd1)
                    begin
                        digits_next = 3'd0;
                        phase_next  = esud_pkg::PH_TEXT;
                        acc_next    = 16'h0000;
                        job.b0      = enc.b0;
                        job.b1      = enc.b1;
                        job.b2      = enc.b2;
                        job.count   = enc.count;
                    end
                    else
                    begin
                        acc_next    = acc_shift;
                        digits_next = digits_reg - 3'd1;
                    end
                end
                default:
                begin
                    phase_next = esud_pkg::PH_TEXT;
                    if (in_byte == esud_pkg::CH_BSLASH)
                        phase_next = esud_pkg::PH_ESC;
                    else
                    begin
                        job.b0    = in_byte;
                        job.count = 2'd1;
                    end
                end
            endcase

            if (end_of_string && phase_next != esud_pkg::PH_TEXT)
                err = 1'b1;

            if (err)
            begin
                job           = '0;
                job.count     = 2'd1;
                job.err       = 1'b1;
                job.eos       = end_of_string;
                phase_next    = esud_pkg::PH_TEXT;
                digits_next   = 3'd0;
                acc_next      = 16'h0000;
                rejected_next = !end_of_string;
            end
            else if (end_of_string)
            begin
                phase_next  = esud_pkg::PH_TEXT;
                digits_next = 3'd0;
                acc_next    = 16'h0000;
            end
        end
    end

    assign push     = accept && (job.count != 2'd0);
    assign push_job = job;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= esud_pkg::PH_TEXT;
            digits_reg   <= 3'd0;
            acc_reg      <= 16'h0000;
            rejected_reg <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg    <= phase_next;
            digits_reg   <= digits_next;
            acc_reg      <= acc_next;
            rejected_reg <= rejected_next;
        end
    end

endmodule

// File: rtl/esud_queue.sv
`timescale 1ns / 1ps
// Small job queue between front and back ends.
// Depends on esud_pkg.
module esud_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  esud_pkg::job_t    push_job,
    input  logic              pop,
    output esud_pkg::job_t    head_job,
    output logic              empty,
    output logic              full
);

    esud_pkg::job_t                 mem_reg [esud_pkg::QueueDepth];
    logic [esud_pkg::QueueAw-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [esud_pkg::QueueAw:0]     count_reg, count_next;

    assign empty    = (count_reg == '0);
    assign full     = (count_reg == (esud_pkg::QueueAw+1)'(esud_pkg::QueueDepth));
    assign head_job = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !(pop && !empty))
            count_next = count_reg + 1'b1;
        else if (!push && pop && !empty)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop && !empty)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

endmodule

// File: rtl/esud_back.sv
`timescale 1ns / 1ps
// Back end: one result per cycle from the queue unless stalled; registered output.
// Depends on esud_pkg.
module esud_back (
    input  logic              clk,
    input  logic              rst_n,
    input  esud_pkg::job_t    head_job,
    input  logic              empty,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [7:0]        out_byte,
    output logic              error,
    output logic              string_done,
    output logic              run_last
);

    logic [1:0] idx_reg;
    logic       valid_reg;
    logic [7:0] byte_reg;
    logic       err_reg, done_reg, last_reg;
    logic       load;
    logic       last;
    logic [7:0] sel_byte;

    assign load = !empty && (!valid_reg || !out_stall);
    assign last = (idx_reg == head_job.count - 2'd1);
    assign pop  = load && last;

    always_comb
    begin
        case (idx_reg)
            2'd1:    sel_byte = head_job.b1;
            2'd2:    sel_byte = head_job.b2;
            default: sel_byte = head_job.b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end
        else
        begin
            if (load)
            begin
                valid_reg <= 1'b1;
                idx_reg   <= last ? 2'd0 : idx_reg + 2'd1;
            end
            else if (!out_stall)
                valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg <= sel_byte;
            err_reg  <= head_job.err;
            done_reg <= head_job.eos && last;
            last_reg <= last;
        end
    end

    assign out_valid   = valid_reg;
    assign out_byte    = byte_reg;
    assign error       = err_reg;
    assign string_done = done_reg;
    assign run_last    = last_reg;

endmodule

// File: rtl/escape_sequence_utf8_decoder.sv
`timescale 1ns / 1ps
// Escape decoder top level: front end, 4-entry job queue, back end.
// Depends on esud_pkg, esud_front, esud_queue, esud_back.
//
// Accepts one string byte per cycle unless in_stall and emits one result byte
// per cycle unless out_stall. A byte that yields N results (1 to 3, UTF-8 from
// a hex escape) holds the output for all N; the 4-entry job queue between
// decoder and serializer absorbs that, and input stalls only when the queue
// is full. Bytes that give no result (backslash, hex digits before the last,
// bytes of a rejected string) never reach the queue. The first result of a
// request passes the job queue, then the back end output register. An error
// gives one result with out_byte 0 and error set; the rest of that string is
// dropped up to its last byte, which again gives one error result.
module escape_sequence_utf8_decoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  in_byte,
    input  logic        end_of_string,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  out_byte,
    output logic        error,
    output logic        string_done,
    output logic        run_last
);

    esud_pkg::job_t push_job, head_job;
    logic           push, pop, q_empty, q_full;

    esud_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_byte       (in_byte),
        .end_of_string (end_of_string),
        .in_stall      (in_stall),
        .q_full        (q_full),
        .push          (push),
        .push_job      (push_job)
    );

    esud_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .empty    (q_empty),
        .full     (q_full)
    );

    esud_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_job    (head_job),
        .empty       (q_empty),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_byte    (out_byte),
        .error       (error),
        .string_done (string_done),
        .run_last    (run_last)
    );

endmodule

// File: rtl/esud_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the escape decoder, bound to the top level.
// Depends on escape_sequence_utf8_decoder ports only.
module esud_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic [7:0] in_byte,
    input logic       end_of_string,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] out_byte,
    input logic       error,
    input logic       string_done,
    input logic       run_last
);

    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(in_byte) && $stable(end_of_string))
        else $error("stalled request changed");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(error)
            && $stable(string_done) && $stable(run_last))
        else $error("stalled result changed");

    a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && error |-> run_last && out_byte == 8'h00)
        else $error("error result not a lone zero byte");

    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && string_done |-> run_last)
        else $error("string end not on last result of request");

    a_err_run: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !run_last |=> out_valid && !error)
        else $error("error inside a multi-byte run");

endmodule

bind escape_sequence_utf8_decoder esud_checker u_esud_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_byte       (in_byte),
    .end_of_string (end_of_string),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_byte      (out_byte),
    .error         (error),
    .string_done   (string_done),
    .run_last      (run_last)
);
